FILE: hw/rtl/grmp_pkg.sv
// Package with shared constants, codes and control types of the grid path block.
`timescale 1ns / 1ps
package grmp_pkg;

	localparam int MAX_SIDE  = 64;
	localparam int MAX_TILE  = 5;
	localparam int DIST_BITS = 20;

	localparam int REG_W     = 7;
	localparam int TILE_W    = 3;
	localparam int DIGIT_W   = 4;
	localparam int OUT_W     = 20;
	localparam int CFG_IDX_W = 2;
	localparam int COST_W    = 5;
	localparam int DIGIT_TOP = 9;

	localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TILES = 2'd2;

	typedef enum logic [2:0] {
		RD_SELF,
		RD_UP,
		RD_DN,
		RD_LF,
		RD_RT,
		RD_LAST
	} rd_t;

	typedef enum logic [1:0] {
		CAP_NONE,
		CAP_SELF,
		CAP_NB
	} cap_t;

	typedef struct packed {
		logic load;
		logic start;
		logic dims;
		logic count;
		logic clear;
		logic pass;
		logic step;
		rd_t  rd;
		cap_t cap;
		logic wb;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic cell_last;
		logic changed;
		logic out_free;
	} sts_t;

endpackage

FILE: hw/rtl/grmp_ram.sv
// Generic single-write, single-read memory with registered read data.
`timescale 1ns / 1ps
module grmp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: hw/rtl/grmp_ctrl.sv
// Controller state machine that sequences loading, clearing, relaxation passes and output.
`timescale 1ns / 1ps
module grmp_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           acc,
	input  logic           last_cell,
	input  grmp_pkg::sts_t sts,
	output grmp_pkg::cmd_t cmd,
	output logic           busy
);

	typedef enum logic [12:0] {
		ST_IDLE   = 13'b0000000000001,
		ST_DIMS   = 13'b0000000000010,
		ST_COUNT  = 13'b0000000000100,
		ST_CLEAR  = 13'b0000000001000,
		ST_A0     = 13'b0000000010000,
		ST_A1     = 13'b0000000100000,
		ST_A2     = 13'b0000001000000,
		ST_A3     = 13'b0000010000000,
		ST_A4     = 13'b0000100000000,
		ST_WB     = 13'b0001000000000,
		ST_FIN_RD = 13'b0010000000000,
		ST_FIN_WT = 13'b0100000000000,
		ST_SPARE  = 13'b1000000000000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		cmd.rd    = grmp_pkg::RD_SELF;
		cmd.cap   = grmp_pkg::CAP_NONE;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load  = acc;
				cmd.start = acc & last_cell;
				if (acc && last_cell) begin
					state_d = ST_DIMS;
				end
			end
			ST_DIMS: begin
				cmd.dims = 1'b1;
				state_d  = ST_COUNT;
			end
			ST_COUNT: begin
				cmd.count = 1'b1;
				state_d   = ST_CLEAR;
			end
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_last) begin
					cmd.pass = 1'b1;
					state_d  = ST_A0;
				end
			end
			ST_A0: begin
				cmd.rd  = grmp_pkg::RD_SELF;
				state_d = ST_A1;
			end
			ST_A1: begin
				cmd.rd  = grmp_pkg::RD_UP;
				cmd.cap = grmp_pkg::CAP_SELF;
				state_d = ST_A2;
			end
			ST_A2: begin
				cmd.rd  = grmp_pkg::RD_DN;
				cmd.cap = grmp_pkg::CAP_NB;
				state_d = ST_A3;
			end
			ST_A3: begin
				cmd.rd  = grmp_pkg::RD_LF;
				cmd.cap = grmp_pkg::CAP_NB;
				state_d = ST_A4;
			end
			ST_A4: begin
				cmd.rd  = grmp_pkg::RD_RT;
				cmd.cap = grmp_pkg::CAP_NB;
				state_d = ST_WB;
			end
			ST_WB: begin
				cmd.cap = grmp_pkg::CAP_NB;
				cmd.wb  = 1'b1;
				if (!sts.cell_last) begin
					cmd.step = 1'b1;
					state_d  = ST_A0;
				end else if (sts.changed) begin
					cmd.pass = 1'b1;
					state_d  = ST_A0;
				end else begin
					state_d = ST_FIN_RD;
				end
			end
			ST_FIN_RD: begin
				cmd.rd  = grmp_pkg::RD_LAST;
				state_d = ST_FIN_WT;
			end
			ST_FIN_WT: begin
				cmd.rd = grmp_pkg::RD_LAST;
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

FILE: hw/rtl/grmp_dp.sv
// Datapath with the digit and distance memories, scan counters, cost and relaxation logic.
`timescale 1ns / 1ps
module grmp_dp #(
	parameter int MAX_SIDE  = grmp_pkg::MAX_SIDE,
	parameter int MAX_TILE  = grmp_pkg::MAX_TILE,
	parameter int DIST_BITS = grmp_pkg::DIST_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  grmp_pkg::cmd_t                    cmd,
	output grmp_pkg::sts_t                    sts,
	input  logic [grmp_pkg::REG_W-1:0]        grid_rows,
	input  logic [grmp_pkg::REG_W-1:0]        grid_cols,
	input  logic [grmp_pkg::TILE_W-1:0]       tile_factor,
	input  logic [grmp_pkg::DIGIT_W-1:0]      risk_digit,
	input  logic                              result_stall,
	output logic                              result_valid,
	output logic [grmp_pkg::OUT_W-1:0]        min_total_risk
);

	localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;
	localparam int SPAN        = MAX_SIDE * MAX_TILE;
	localparam int CELLS       = SPAN * SPAN;
	localparam int ST_W        = STORE_DEPTH > 1 ? $clog2(STORE_DEPTH) : 1;
	localparam int CELL_W      = CELLS > 1 ? $clog2(CELLS) : 1;
	localparam int SIDE_W      = $clog2(MAX_SIDE + 1);
	localparam int TL_W        = $clog2(MAX_TILE + 1);
	localparam int SPAN_W      = $clog2(SPAN + 1);
	localparam int N_W         = $clog2(CELLS + 1);
	localparam int CW          = grmp_pkg::COST_W;
	localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

	logic [SIDE_W-1:0]    rows_q, cols_q, br_q, bc_q;
	logic [TL_W-1:0]      tiles_q, tr_q, tc_q;
	logic [SPAN_W-1:0]    allr_q, allc_q, r_q, c_q;
	logic [N_W-1:0]       n_q;
	logic [CELL_W-1:0]    idx_q, clr_q, last_idx, allc_ext, raddr;
	logic [ST_W-1:0]      boff_q, load_q, risk_raddr;
	logic [DIST_BITS-1:0] cur_q, best_q, best_fold, cand, wdata, drd;
	logic [DIST_BITS:0]   sum;
	logic [CW-1:0]        cost_q, craw, cost;
	logic [3:0]           risk_rd;
	logic                 nbv_s1, nb_ok, improve, changed_q, we, out_valid_q;
	logic [grmp_pkg::OUT_W-1:0] out_q;
	logic [31:0]          drd_ext;

	grmp_ram #(.WIDTH(grmp_pkg::DIGIT_W), .DEPTH(STORE_DEPTH)) u_risk (
		.clk   (clk),
		.we    (cmd.load),
		.waddr (load_q),
		.wdata (risk_digit),
		.raddr (risk_raddr),
		.rdata (risk_rd)
	);

	grmp_ram #(.WIDTH(DIST_BITS), .DEPTH(CELLS)) u_dist (
		.clk   (clk),
		.we    (we),
		.waddr (cmd.clear ? clr_q : idx_q),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (drd)
	);

	assign risk_raddr = boff_q + ST_W'(bc_q);
	assign allc_ext   = CELL_W'(allc_q);
	assign last_idx   = CELL_W'(n_q - N_W'(1));

	always_comb begin
		nb_ok = 1'b0;
		raddr = idx_q;
		unique case (cmd.rd)
			grmp_pkg::RD_SELF: begin
				raddr = idx_q;
			end
			grmp_pkg::RD_UP: begin
				nb_ok = (r_q != '0);
				raddr = nb_ok ? idx_q - allc_ext : idx_q;
			end
			grmp_pkg::RD_DN: begin
				nb_ok = (r_q != allr_q - SPAN_W'(1));
				raddr = nb_ok ? idx_q + allc_ext : idx_q;
			end
			grmp_pkg::RD_LF: begin
				nb_ok = (c_q != '0);
				raddr = nb_ok ? idx_q - CELL_W'(1) : idx_q;
			end
			grmp_pkg::RD_RT: begin
				nb_ok = (c_q != allc_q - SPAN_W'(1));
				raddr = nb_ok ? idx_q + CELL_W'(1) : idx_q;
			end
			grmp_pkg::RD_LAST: begin
				raddr = last_idx;
			end
			default: begin
				raddr = idx_q;
			end
		endcase
	end

	assign craw      = CW'(risk_rd) + CW'(tr_q) + CW'(tc_q);
	assign cost      = (craw > CW'(grmp_pkg::DIGIT_TOP)) ? craw - CW'(grmp_pkg::DIGIT_TOP) : craw;
	assign best_fold = (nbv_s1 && drd < best_q) ? drd : best_q;
	assign sum       = {1'b0, best_fold} + (DIST_BITS + 1)'(cost_q);
	assign cand      = sum[DIST_BITS] ? DIST_MAX : sum[DIST_BITS-1:0];
	assign improve   = cmd.wb && (cand < cur_q);
	assign we        = cmd.clear || improve;
	assign wdata     = cmd.clear ? ((clr_q == '0) ? '0 : DIST_MAX) : cand;
	assign drd_ext   = 32'(drd);

	assign sts.clear_last = (clr_q == last_idx);
	assign sts.cell_last  = (idx_q == last_idx);
	assign sts.changed    = changed_q | improve;
	assign sts.out_free   = !out_valid_q || !result_stall;

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rows_q  <= (grid_rows == '0) ? SIDE_W'(1) :
				(int'(grid_rows) > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : SIDE_W'(grid_rows);
			cols_q  <= (grid_cols == '0) ? SIDE_W'(1) :
				(int'(grid_cols) > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : SIDE_W'(grid_cols);
			tiles_q <= (tile_factor == '0) ? TL_W'(1) :
				(int'(tile_factor) > MAX_TILE) ? TL_W'(MAX_TILE) : TL_W'(tile_factor);
		end
		if (cmd.dims) begin
			allr_q <= SPAN_W'(rows_q) * SPAN_W'(tiles_q);
			allc_q <= SPAN_W'(cols_q) * SPAN_W'(tiles_q);
		end
		if (cmd.count) begin
			n_q   <= N_W'(allr_q) * N_W'(allc_q);
			clr_q <= '0;
		end else if (cmd.clear) begin
			clr_q <= clr_q + CELL_W'(1);
		end
		nbv_s1 <= nb_ok;
		if (cmd.cap == grmp_pkg::CAP_SELF) begin
			cur_q  <= drd;
			best_q <= DIST_MAX;
			cost_q <= cost;
		end else if (cmd.cap == grmp_pkg::CAP_NB) begin
			best_q <= best_fold;
		end
		if (cmd.pass) begin
			idx_q  <= '0;
			r_q    <= '0;
			c_q    <= '0;
			br_q   <= '0;
			bc_q   <= '0;
			tr_q   <= '0;
			tc_q   <= '0;
			boff_q <= '0;
		end else if (cmd.step) begin
			idx_q <= idx_q + CELL_W'(1);
			if (c_q == allc_q - SPAN_W'(1)) begin
				c_q  <= '0;
				bc_q <= '0;
				tc_q <= '0;
				r_q  <= r_q + SPAN_W'(1);
				if (br_q == rows_q - SIDE_W'(1)) begin
					br_q   <= '0;
					tr_q   <= tr_q + TL_W'(1);
					boff_q <= '0;
				end else begin
					br_q   <= br_q + SIDE_W'(1);
					boff_q <= boff_q + ST_W'(cols_q);
				end
			end else begin
				c_q <= c_q + SPAN_W'(1);
				if (bc_q == cols_q - SIDE_W'(1)) begin
					bc_q <= '0;
					tc_q <= tc_q + TL_W'(1);
				end else begin
					bc_q <= bc_q + SIDE_W'(1);
				end
			end
		end
		if (cmd.emit) begin
			out_q <= drd_ext[grmp_pkg::OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_q      <= '0;
			changed_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				load_q <= '0;
			end else if (cmd.load) begin
				load_q <= (int'(load_q) == STORE_DEPTH - 1) ? '0 : load_q + ST_W'(1);
			end
			if (cmd.pass) begin
				changed_q <= 1'b0;
			end else if (improve) begin
				changed_q <= 1'b1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid   = out_valid_q;
	assign min_total_risk = out_q;

endmodule

FILE: hw/rtl/grid_min_risk_path.sv
// Top level of the least-risk grid path block: configuration registers and the two halves.
`timescale 1ns / 1ps
// Risk digits load one request per cycle in row-major order while idle. The request that
// carries last_cell starts a search, and the block stalls new requests until it has
// handed its result to the output register. The search computes the tiled dimensions,
// then the cell count N (tiled rows times tiled columns), clears the distance memory
// over N cells, then runs relaxation sweeps until one improves no distance (at least
// one sweep), and finally reads out the last cell's distance. Per cell, the single-read
// distance memory is read once for the cell and once for each of its four neighbours.
// A finished result waits in the output register while the next grid loads.
module grid_min_risk_path #(
	parameter int MAX_SIDE  = grmp_pkg::MAX_SIDE,
	parameter int MAX_TILE  = grmp_pkg::MAX_TILE,
	parameter int DIST_BITS = grmp_pkg::DIST_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [grmp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [grmp_pkg::REG_W-1:0]        cfg_data,
	input  logic                              risk_valid,
	output logic                              risk_stall,
	input  logic [grmp_pkg::DIGIT_W-1:0]      risk_digit,
	input  logic                              last_cell,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic [grmp_pkg::OUT_W-1:0]        min_total_risk
);

	logic [grmp_pkg::REG_W-1:0]  rows_q, cols_q;
	logic [grmp_pkg::TILE_W-1:0] tiles_q;
	logic                        acc, busy;
	grmp_pkg::cmd_t              cmd;
	grmp_pkg::sts_t              sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= grmp_pkg::REG_W'(1);
			cols_q  <= grmp_pkg::REG_W'(1);
			tiles_q <= grmp_pkg::TILE_W'(1);
		end else if (cfg_we) begin
			if (cfg_index == grmp_pkg::CFG_ROWS) begin
				rows_q <= cfg_data;
			end else if (cfg_index == grmp_pkg::CFG_COLS) begin
				cols_q <= cfg_data;
			end else if (cfg_index == grmp_pkg::CFG_TILES) begin
				tiles_q <= cfg_data[grmp_pkg::TILE_W-1:0];
			end
		end
	end

	assign risk_stall = busy;
	assign acc        = risk_valid && !busy;

	grmp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.last_cell (last_cell),
		.sts       (sts),
		.cmd       (cmd),
		.busy      (busy)
	);

	grmp_dp #(
		.MAX_SIDE  (MAX_SIDE),
		.MAX_TILE  (MAX_TILE),
		.DIST_BITS (DIST_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.grid_rows      (rows_q),
		.grid_cols      (cols_q),
		.tile_factor    (tiles_q),
		.risk_digit     (risk_digit),
		.result_stall   (result_stall),
		.result_valid   (result_valid),
		.min_total_risk (min_total_risk)
	);

`ifndef SYNTH
	a_start_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(risk_valid && !risk_stall && last_cell) |=> risk_stall)
		else $error("search did not stall the input");

	a_result_after_search: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(risk_stall))
		else $error("result appeared without a search");

	a_no_load_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !cmd.load)
		else $error("digit written during a search");
`endif

endmodule
